// ----- hw/rtl/block_mapped_flash_translation_defines.svh -----
// Assertion macros used by the flash translation top level.
`ifndef BLOCK_MAPPED_FLASH_TRANSLATION_DEFINES_SVH
`define BLOCK_MAPPED_FLASH_TRANSLATION_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define BMFT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle while arst_n is low.
`define BMFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/bmft_pkg.sv -----
// Shared constants, payload types and control structs of the flash translation block.
package bmft_pkg;

	// Geometry of the flash array.
	localparam int NUM_BLOCKS        = 64;
	localparam int SECTORS_PER_BLOCK = 32;
	localparam int DATA_BITS         = 32;
	localparam int BLK_W             = $clog2(NUM_BLOCKS);
	localparam int OFF_W             = $clog2(SECTORS_PER_BLOCK);
	localparam int SEC_W             = BLK_W + OFF_W;
	localparam int TOTAL_SECTORS     = NUM_BLOCKS * SECTORS_PER_BLOCK;
	localparam int CNT_W             = OFF_W + 1;

	// Field widths of the channels.
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 11;
	localparam int WDATA_W  = 32;
	localparam int STATUS_W = 2;
	localparam int PB_W     = 6;
	localparam int SOFF_W   = 5;
	localparam int CNTF_W   = 6;
	localparam int LIMIT_W  = 11;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1984;

	// Range limits in the widths they are compared at.
	localparam logic [ADDR_W:0]   TOTAL_X   = TOTAL_SECTORS[ADDR_W:0];
	localparam logic [ADDR_W-1:0] MAP_LIM_X = NUM_BLOCKS[ADDR_W-1:0];
	localparam logic [BLK_W-1:0]  SPARE_IDX = BLK_W'(NUM_BLOCKS - 1);
	localparam logic [CNT_W-1:0]  COPY_LAST = CNT_W'(SECTORS_PER_BLOCK);

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_MAP   = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_RELOC   = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	// Which kind of result the output register is loaded with.
	typedef enum logic [2:0] {
		RES_INVALID,
		RES_INPLACE,
		RES_RELOC,
		RES_READ,
		RES_MAP
	} res_kind_t;

	typedef logic [LIMIT_W-1:0] limit_t;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [ADDR_W-1:0]  address;
		logic [WDATA_W-1:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PB_W-1:0]     physical_block;
		logic [SOFF_W-1:0]   sector_offset;
		logic                occupied;
		logic [WDATA_W-1:0]  read_data;
		logic [CNTF_W-1:0]   sector_writes;
		logic [CNTF_W-1:0]   sector_erases;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load_in;
		logic      rd_first;
		logic      rd_row;
		logic      wr_inplace;
		logic      copy_start;
		logic      copy_step;
		logic      remap;
		logic      res_load;
		res_kind_t kind;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_write;
		logic is_read;
		logic is_map;
		logic wr_bad;
		logic rd_bad;
		logic map_bad;
		logic taken;
		logic copy_done;
	} dp_stat_t;

endpackage

// ----- hw/rtl/bmft_chan_if.sv -----
// Valid/ready channel interface carrying one payload per transfer.
interface bmft_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bmft_dpath.sv -----
// Datapath: map table, sector-used rows, sector store, copy walk and result register.
module bmft_dpath #(
	parameter int DATA_BITS = bmft_pkg::DATA_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmft_pkg::dp_cmd_t    ctl,
	output bmft_pkg::dp_stat_t   stat,
	input  bmft_pkg::in_item_t   item,
	input  logic                 cfg_we,
	input  bmft_pkg::limit_t     cfg_data,
	output bmft_pkg::out_item_t  result
);

	localparam int NB     = bmft_pkg::NUM_BLOCKS;
	localparam int SPB    = bmft_pkg::SECTORS_PER_BLOCK;
	localparam int TOTAL  = bmft_pkg::TOTAL_SECTORS;
	localparam int BLK_W  = bmft_pkg::BLK_W;
	localparam int OFF_W  = bmft_pkg::OFF_W;
	localparam int SEC_W  = bmft_pkg::SEC_W;
	localparam int CNT_W  = bmft_pkg::CNT_W;
	localparam int ADDR_W = bmft_pkg::ADDR_W;
	localparam int WD_W   = bmft_pkg::WDATA_W;
	localparam int PB_W   = bmft_pkg::PB_W;
	localparam int SOFF_W = bmft_pkg::SOFF_W;
	localparam int CNTF_W = bmft_pkg::CNTF_W;

	// Captured item and configuration.
	logic [bmft_pkg::OP_W-1:0] op_q;
	logic [ADDR_W-1:0]         addr_q;
	logic [DATA_BITS-1:0]      data_q;
	bmft_pkg::limit_t          limit_q;

	// Block bookkeeping.
	logic [BLK_W-1:0] spare_q;
	logic [BLK_W-1:0] old_pb_q;
	logic [NB-1:0]    map_vld_q;
	logic [NB-1:0]    row_vld_q;

	// Memories.
	logic [BLK_W-1:0]     map_mem   [NB];
	logic [SPB-1:0]       row_mem   [NB];
	logic [DATA_BITS-1:0] store_mem [TOTAL];

	// Registered read data.
	logic [BLK_W-1:0]     map_rdata_q;
	logic [BLK_W-1:0]     map_ridx_q;
	logic                 map_rvld_q;
	logic [SPB-1:0]       row_rdata_q;
	logic                 row_rvld_q;
	logic [DATA_BITS-1:0] store_rdata_q;

	// Copy walk.
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] writes_q;
	logic [CNT_W-1:0] erases_q;

	bmft_pkg::out_item_t result_q;
	bmft_pkg::out_item_t res_d;

	logic [BLK_W-1:0]     lb;
	logic [OFF_W-1:0]     off;
	logic [SPB-1:0]       off_bit;
	logic [SPB-1:0]       row_eff;
	logic [BLK_W-1:0]     map_val;
	logic [BLK_W-1:0]     map_raddr;
	logic [BLK_W-1:0]     row_raddr;
	logic [OFF_W-1:0]     cur;
	logic [OFF_W-1:0]     prev;
	logic                 cp_wr;
	logic                 cp_erase;
	logic [SEC_W-1:0]     store_raddr;
	logic                 store_we;
	logic [SEC_W-1:0]     store_waddr;
	logic [DATA_BITS-1:0] store_wdata;

	// Address split and effective views of the registered reads.
	always_comb begin
		lb      = addr_q[OFF_W +: BLK_W];
		off     = addr_q[OFF_W-1:0];
		off_bit = '0;
		off_bit[off] = 1'b1;
		row_eff = row_rvld_q ? row_rdata_q : '0;
		map_val = map_rvld_q ? map_rdata_q : (bmft_pkg::SPARE_IDX - map_ridx_q);
	end

	// Read addresses and the copy walk write decision.
	always_comb begin
		map_raddr   = (op_q == bmft_pkg::OP_MAP) ? addr_q[BLK_W-1:0] : lb;
		row_raddr   = ctl.rd_row ? map_val : lb;
		cur         = idx_q[OFF_W-1:0];
		prev        = cur - OFF_W'(1);
		cp_erase    = ctl.copy_step && (idx_q != '0) && row_eff[prev];
		cp_wr       = ctl.copy_step && (idx_q != '0) && ((prev == off) || row_eff[prev]);
		store_raddr = ctl.copy_step ? {old_pb_q, cur} : addr_q[SEC_W-1:0];
		store_we    = ctl.wr_inplace || cp_wr;
		if (ctl.wr_inplace) begin
			store_waddr = {old_pb_q, off};
			store_wdata = data_q;
		end else begin
			store_waddr = {spare_q, prev};
			store_wdata = (prev == off) ? data_q : store_rdata_q;
		end
	end

	// Decode and range checks for the controller.
	always_comb begin
		stat.is_write  = (op_q == bmft_pkg::OP_WRITE);
		stat.is_read   = (op_q == bmft_pkg::OP_READ);
		stat.is_map    = (op_q == bmft_pkg::OP_MAP);
		stat.wr_bad    = (addr_q >= limit_q) || (lb >= bmft_pkg::SPARE_IDX);
		stat.rd_bad    = ({1'b0, addr_q} >= bmft_pkg::TOTAL_X);
		stat.map_bad   = (addr_q >= bmft_pkg::MAP_LIM_X);
		stat.taken     = row_eff[off];
		stat.copy_done = (idx_q == bmft_pkg::COPY_LAST);
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			op_q   <= item.operation;
			addr_q <= item.address;
			data_q <= DATA_BITS'(item.write_data);
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bmft_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	// Spare block and the valid bits of map entries and used rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spare_q   <= bmft_pkg::SPARE_IDX - bmft_pkg::SPARE_IDX;
			map_vld_q <= '0;
			row_vld_q <= '0;
		end else begin
			if (ctl.wr_inplace) begin
				row_vld_q[old_pb_q] <= 1'b1;
			end
			if (ctl.remap) begin
				spare_q       <= old_pb_q;
				map_vld_q[lb] <= 1'b1;
				// The old block reads as erased and the spare takes over its row.
				row_vld_q     <= (row_vld_q & ~(NB'(1) << old_pb_q)) | (NB'(1) << spare_q);
			end
		end
	end

	// Block being written; after a relocation it swaps with the spare.
	always_ff @(posedge clk) begin
		if (ctl.rd_row) begin
			old_pb_q <= map_val;
		end else if (ctl.remap) begin
			old_pb_q <= spare_q;
		end
	end

	// Map table memory.
	always_ff @(posedge clk) begin
		if (ctl.remap) begin
			map_mem[lb] <= spare_q;
		end
		if (ctl.rd_first) begin
			map_rdata_q <= map_mem[map_raddr];
			map_rvld_q  <= map_vld_q[map_raddr];
			map_ridx_q  <= map_raddr;
		end
	end

	// Sector-used row memory, one row of flags per physical block.
	always_ff @(posedge clk) begin
		if (ctl.wr_inplace) begin
			row_mem[old_pb_q] <= row_eff | off_bit;
		end else if (ctl.remap) begin
			row_mem[spare_q] <= row_eff;
		end
		if (ctl.rd_first || ctl.rd_row) begin
			row_rdata_q <= row_mem[row_raddr];
			row_rvld_q  <= row_vld_q[row_raddr];
		end
	end

	// Sector store memory.
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_waddr] <= store_wdata;
		end
		if (ctl.rd_first || ctl.copy_step) begin
			store_rdata_q <= store_mem[store_raddr];
		end
	end

	// Copy walk counters: one source read and at most one spare write per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctl.copy_start) begin
			idx_q <= '0;
		end else if (ctl.copy_step) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.copy_start) begin
			writes_q <= '0;
			erases_q <= '0;
		end else begin
			if (cp_wr) begin
				writes_q <= writes_q + CNT_W'(1);
			end
			if (cp_erase) begin
				erases_q <= erases_q + CNT_W'(1);
			end
		end
	end

	// Next result, by the kind the controller selects.
	always_comb begin
		res_d = '0;
		case (ctl.kind)
			bmft_pkg::RES_INPLACE: begin
				res_d.status         = bmft_pkg::ST_OK;
				res_d.physical_block = PB_W'(old_pb_q);
				res_d.sector_offset  = SOFF_W'(off);
				res_d.sector_writes  = CNTF_W'(1);
			end
			bmft_pkg::RES_RELOC: begin
				res_d.status         = bmft_pkg::ST_RELOC;
				res_d.physical_block = PB_W'(old_pb_q);
				res_d.sector_offset  = SOFF_W'(off);
				res_d.sector_writes  = CNTF_W'(writes_q);
				res_d.sector_erases  = CNTF_W'(erases_q);
			end
			bmft_pkg::RES_READ: begin
				res_d.status         = bmft_pkg::ST_OK;
				res_d.physical_block = PB_W'(lb);
				res_d.sector_offset  = SOFF_W'(off);
				res_d.occupied       = row_eff[off];
				res_d.read_data      = row_eff[off] ? WD_W'(store_rdata_q) : '0;
			end
			bmft_pkg::RES_MAP: begin
				res_d.status         = bmft_pkg::ST_OK;
				res_d.physical_block = (map_ridx_q == bmft_pkg::SPARE_IDX) ?
					PB_W'(spare_q) : PB_W'(map_val);
			end
			default: begin
				res_d.status = bmft_pkg::ST_INVALID;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			result_q <= res_d;
		end
	end

	assign result = result_q;

endmodule

// ----- hw/rtl/bmft_ctrl.sv -----
// Controller: sequences lookup, in-place program, relocation walk and result delivery.
module bmft_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output bmft_pkg::dp_cmd_t  ctl,
	input  bmft_pkg::dp_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_DECODE,
		S_CHECK,
		S_COPY,
		S_REMAP,
		S_DONE
	} state_t;

	state_t                state_q;
	bmft_pkg::res_kind_t   kind_q;
	logic                  out_valid_q;

	// Commands decoded from the current state.
	always_comb begin
		ctl      = '0;
		ctl.kind = kind_q;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE:   ctl.load_in  = in_valid;
			S_FETCH:  ctl.rd_first = 1'b1;
			S_DECODE: ctl.rd_row   = stat.is_write && !stat.wr_bad;
			S_CHECK: begin
				ctl.copy_start = stat.taken;
				ctl.wr_inplace = !stat.taken;
			end
			S_COPY:   ctl.copy_step = 1'b1;
			S_REMAP:  ctl.remap     = 1'b1;
			S_DONE:   ctl.res_load  = !out_valid_q || out_ready;
			default:  ctl.kind      = kind_q;
		endcase
	end

	// State, result kind and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= bmft_pkg::RES_INVALID;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_DECODE;
				S_DECODE: begin
					if (stat.is_write) begin
						if (stat.wr_bad) begin
							kind_q  <= bmft_pkg::RES_INVALID;
							state_q <= S_DONE;
						end else begin
							state_q <= S_CHECK;
						end
					end else if (stat.is_read) begin
						kind_q  <= stat.rd_bad ? bmft_pkg::RES_INVALID : bmft_pkg::RES_READ;
						state_q <= S_DONE;
					end else if (stat.is_map) begin
						kind_q  <= stat.map_bad ? bmft_pkg::RES_INVALID : bmft_pkg::RES_MAP;
						state_q <= S_DONE;
					end else begin
						kind_q  <= bmft_pkg::RES_INVALID;
						state_q <= S_DONE;
					end
				end
				S_CHECK: begin
					if (stat.taken) begin
						state_q <= S_COPY;
					end else begin
						kind_q  <= bmft_pkg::RES_INPLACE;
						state_q <= S_DONE;
					end
				end
				S_COPY: begin
					if (stat.copy_done) begin
						state_q <= S_REMAP;
					end
				end
				S_REMAP: begin
					kind_q  <= bmft_pkg::RES_RELOC;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (ctl.res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/block_mapped_flash_translation.sv -----
// Block-mapped flash translation layer: top level wiring the controller and datapath.
//
// Channels: cmd carries one request (operation, address, write_data) per transfer;
// rsp returns exactly one result per request, in order; cfg writes sector_limit and is
// always ready, and must only be written while no request is in flight.
// Operations: write a logical sector, read a physical sector, read a map entry.
// A write to a free sector programs it in place; a write to a taken sector copies
// the block into the spare, erases the old block and swaps the two in the map.
// The relocation walk reads one source sector and programs at most one spare sector
// per cycle through the single read and write port of the sector store.
// The result register sits between the two sides: cmd is taken again as soon as
// a result is loaded, even while rsp is stalled; a second result waits inside until
// the first transfer completes.
// Reset (arst_n low) restores the identity-reversed map, marks all sectors erased
// and sets sector_limit to 1984; no clearing pass is needed.
`include "block_mapped_flash_translation_defines.svh"

module block_mapped_flash_translation #(
	parameter int DATA_BITS = bmft_pkg::DATA_BITS
) (
	input logic        clk,
	input logic        arst_n,
	bmft_chan_if.sink   cmd,
	bmft_chan_if.source rsp,
	bmft_chan_if.sink   cfg
);

	bmft_pkg::dp_cmd_t  ctl;
	bmft_pkg::dp_stat_t stat;
	logic               cmd_ready;
	logic               rsp_valid;

	bmft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd_ready),
		.out_valid (rsp_valid),
		.out_ready (rsp.ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	bmft_dpath #(
		.DATA_BITS (DATA_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.item     (cmd.data),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.result   (rsp.data)
	);

	assign cmd.ready = cmd_ready;
	assign rsp.valid = rsp_valid;
	assign cfg.ready = 1'b1;

	// Every accepted request starts its lookup in the next cycle.
	`BMFT_ASSERT_NEXT(a_accept_fetch, cmd.valid && cmd.ready, ctl.rd_first, "request accepted without lookup")
	// A result is never loaded over one that is still waiting on rsp.
	`BMFT_ASSERT_NOW(a_no_overwrite, ctl.res_load, !rsp_valid || rsp.ready, "pending result overwritten")
	// A loaded result is offered on rsp in the next cycle.
	`BMFT_ASSERT_NEXT(a_load_valid, ctl.res_load, rsp_valid, "loaded result not offered")
	// The map swap only follows a completed copy walk.
	`BMFT_ASSERT_NOW(a_remap_after_copy, ctl.remap, $past(ctl.copy_step) && $past(stat.copy_done), "remap before copy walk finished")

endmodule

// ----- bench/block_mapped_flash_translation_tb.sv -----
// Self-checking testbench for the block-mapped flash translation layer.
module block_mapped_flash_translation_tb;
	import bmft_pkg::*;

	// Operation code that the block must reject.
	localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

	localparam int GAP_MAX       = 4;
	localparam int HOLD_CYCLES   = 90;
	localparam int SETTLE_CYCLES = 48;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int RUN_LIMIT     = 4000000;
	localparam int WRITE_TOP     = int'(SPARE_IDX) * SECTORS_PER_BLOCK;
	localparam int NUM_PHASES    = 6;

	localparam out_item_t RES_REJECT = '{status: ST_INVALID, default: '0};

	// One row of the directed table; want is used only where given is set.
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [ADDR_W-1:0]  addr;
		logic [WDATA_W-1:0] wdata;
		logic               given;
		out_item_t          want;
	} dir_row_t;

	localparam int DIR_N = 24;
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{OP_MAP, 11'd0, 32'h0, 1'b1, '{ST_OK, 6'd63, 5'd0, 1'b0, 32'h0, 6'd0, 6'd0}},
		'{OP_MAP, 11'd63, 32'hffffffff, 1'b1, '{ST_OK, 6'd0, 5'd0, 1'b0, 32'h0, 6'd0, 6'd0}},
		'{OP_MAP, 11'd64, 32'h0, 1'b1, RES_REJECT},
		'{OP_MAP, 11'd2047, 32'h0, 1'b1, RES_REJECT},
		'{OP_UNKNOWN, 11'd0, 32'h0, 1'b1, RES_REJECT},
		'{OP_UNKNOWN, 11'd2047, 32'hffffffff, 1'b1, RES_REJECT},
		'{OP_WRITE, 11'd0, 32'h0, 1'b1, '{ST_OK, 6'd63, 5'd0, 1'b0, 32'h0, 6'd1, 6'd0}},
		'{OP_WRITE, 11'd31, 32'hffffffff, 1'b1,
			'{ST_OK, 6'd63, 5'd31, 1'b0, 32'h0, 6'd1, 6'd0}},
		'{OP_READ, 11'd2016, 32'h0, 1'b1, '{ST_OK, 6'd63, 5'd0, 1'b1, 32'h0, 6'd0, 6'd0}},
		'{OP_READ, 11'd2047, 32'h0, 1'b1,
			'{ST_OK, 6'd63, 5'd31, 1'b1, 32'hffffffff, 6'd0, 6'd0}},
		'{OP_WRITE, 11'd0, 32'ha5a5a5a5, 1'b1,
			'{ST_RELOC, 6'd0, 5'd0, 1'b0, 32'h0, 6'd2, 6'd2}},
		'{OP_READ, 11'd2016, 32'h0, 1'b1, '{ST_OK, 6'd63, 5'd0, 1'b0, 32'h0, 6'd0, 6'd0}},
		'{OP_READ, 11'd0, 32'h0, 1'b1, '{ST_OK, 6'd0, 5'd0, 1'b1, 32'ha5a5a5a5, 6'd0, 6'd0}},
		'{OP_READ, 11'd31, 32'h0, 1'b1,
			'{ST_OK, 6'd0, 5'd31, 1'b1, 32'hffffffff, 6'd0, 6'd0}},
		'{OP_MAP, 11'd0, 32'h0, 1'b1, '{ST_OK, 6'd0, 5'd0, 1'b0, 32'h0, 6'd0, 6'd0}},
		'{OP_MAP, 11'd63, 32'h0, 1'b1, '{ST_OK, 6'd63, 5'd0, 1'b0, 32'h0, 6'd0, 6'd0}},
		'{OP_WRITE, 11'd1983, 32'h5a5a5a5a, 1'b0, '0},
		'{OP_WRITE, 11'd1984, 32'hffffffff, 1'b1, RES_REJECT},
		'{OP_WRITE, 11'd2016, 32'h0, 1'b1, RES_REJECT},
		'{OP_WRITE, 11'd2047, 32'hffffffff, 1'b1, RES_REJECT},
		'{OP_WRITE, 11'd1, 32'h12345678, 1'b0, '0},
		'{OP_WRITE, 11'd1, 32'h87654321, 1'b0, '0},
		'{OP_READ, 11'd2017, 32'h0, 1'b0, '0},
		'{OP_MAP, 11'd61, 32'h0, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	bmft_chan_if #(.payload_t(in_item_t))  cmd_ch ();
	bmft_chan_if #(.payload_t(out_item_t)) rsp_ch ();
	bmft_chan_if #(.payload_t(limit_t))    cfg_ch ();

	block_mapped_flash_translation u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the translation state.
	logic [BLK_W-1:0]   map_shadow  [NUM_BLOCKS];
	logic [WDATA_W-1:0] data_shadow [TOTAL_SECTORS];
	bit                 used_shadow [TOTAL_SECTORS];
	bit                 ever_written [TOTAL_SECTORS];
	int                 written_list [$];
	limit_t             limit_shadow;

	out_item_t pending_results [$];

	bit tx_steady;
	bit hold_req;
	int hot_lb;
	int n_sent, n_inplace, n_reloc, n_invalid, n_read, n_map, n_cfg, n_holds;
	int max_moved;
	int mismatch_cnt;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT;
		$display("block_mapped_flash_translation_tb: done, errors");
		$finish;
	end

	// Remember which physical sectors have ever held data, so random reads only target those.
	function automatic void mark_written(int s);
		if (!ever_written[s]) begin
			ever_written[s] = 1'b1;
			written_list.push_back(s);
		end
	endfunction

	// Work out the result of one request and advance the shadow state.
	function automatic out_item_t flash_predict(in_item_t req);
		out_item_t        res;
		logic [BLK_W-1:0] lblk;
		logic [BLK_W-1:0] old_pb;
		logic [BLK_W-1:0] spare_pb;
		logic [OFF_W-1:0] off;
		int               src;
		int               dst;
		int               writes;
		int               erases;
		res = '0;
		lblk = req.address[ADDR_W-1:OFF_W];
		off = req.address[OFF_W-1:0];
		writes = 0;
		erases = 0;
		case (req.operation)
			OP_WRITE: begin
				if (req.address >= limit_shadow || lblk == SPARE_IDX) begin
					res.status = ST_INVALID;
					n_invalid++;
				end else begin
					old_pb = map_shadow[lblk];
					spare_pb = map_shadow[SPARE_IDX];
					src = int'(old_pb) * SECTORS_PER_BLOCK + int'(off);
					if (!used_shadow[src]) begin
						// Free target sector: program it where it is.
						data_shadow[src] = req.write_data;
						used_shadow[src] = 1'b1;
						mark_written(src);
						res.status = ST_OK;
						res.physical_block = old_pb;
						res.sector_offset = off;
						res.sector_writes = CNTF_W'(1);
						n_inplace++;
					end else begin
						// Taken target: move the block into the spare and swap the two.
						for (int u = 0; u < SECTORS_PER_BLOCK; u++) begin
							src = int'(old_pb) * SECTORS_PER_BLOCK + u;
							dst = int'(spare_pb) * SECTORS_PER_BLOCK + u;
							if (u == int'(off)) begin
								data_shadow[dst] = req.write_data;
								used_shadow[dst] = 1'b1;
								mark_written(dst);
								writes++;
							end else if (used_shadow[src]) begin
								data_shadow[dst] = data_shadow[src];
								used_shadow[dst] = 1'b1;
								mark_written(dst);
								writes++;
							end
							if (used_shadow[src]) begin
								used_shadow[src] = 1'b0;
								data_shadow[src] = '0;
								erases++;
							end
						end
						map_shadow[lblk] = spare_pb;
						map_shadow[SPARE_IDX] = old_pb;
						res.status = ST_RELOC;
						res.physical_block = spare_pb;
						res.sector_offset = off;
						res.sector_writes = CNTF_W'(writes);
						res.sector_erases = CNTF_W'(erases);
						n_reloc++;
						if (writes > max_moved)
							max_moved = writes;
					end
				end
			end
			OP_READ: begin
				src = int'(req.address);
				res.status = ST_OK;
				res.physical_block = lblk;
				res.sector_offset = off;
				if (used_shadow[src]) begin
					res.occupied = 1'b1;
					res.read_data = data_shadow[src];
				end
				n_read++;
			end
			OP_MAP: begin
				if (req.address < ADDR_W'(NUM_BLOCKS)) begin
					res.status = ST_OK;
					res.physical_block = map_shadow[req.address[BLK_W-1:0]];
				end else begin
					res.status = ST_INVALID;
					n_invalid++;
				end
				n_map++;
			end
			default: begin
				res.status = ST_INVALID;
				n_invalid++;
			end
		endcase
		return res;
	endfunction

	// Payloads lean toward all zeros and all ones now and then.
	function automatic logic [WDATA_W-1:0] pick_payload();
		int r;
		r = $urandom_range(15);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return WDATA_W'($urandom);
	endfunction

	// Write addresses mostly hit a few hot blocks so that sectors collide and relocate.
	function automatic logic [ADDR_W-1:0] pick_write_addr(int top);
		int r;
		int a;
		r = $urandom_range(99);
		if (top == 0 || r < 12)
			return ADDR_W'($urandom_range(2047));
		if (r < 70) begin
			a = (hot_lb + $urandom_range(2)) * SECTORS_PER_BLOCK;
			a += ($urandom_range(1) == 1) ? $urandom_range(7) : $urandom_range(31);
			if (a < top)
				return ADDR_W'(a);
		end
		return ADDR_W'($urandom_range(top - 1));
	endfunction

	// Offer one request after a random gap and record its expected result on transfer.
	task automatic issue_request(in_item_t req, bit given, out_item_t given_res);
		int        gap;
		out_item_t res;
		if ($urandom_range(19) == 0)
			tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(GAP_MAX);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= req;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		res = flash_predict(req);
		pending_results.push_back(given ? given_res : res);
		n_sent++;
	endtask

	// Stop offering and wait until every expected result has come back or the drain limit is reached.
	task automatic settle_idle();
		int waited;
		waited = 0;
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the sector limit register; only called while the block is idle.
	task automatic set_limit(int value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= limit_t'(value);
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		limit_shadow = limit_t'(value);
		n_cfg++;
	endtask

	// Random traffic for one limit setting.
	task automatic run_phase(int count, bit squeeze);
		int        top;
		int        start;
		int        r;
		int        a;
		in_item_t  req;
		top = (int'(limit_shadow) < WRITE_TOP) ? int'(limit_shadow) : WRITE_TOP;
		hot_lb = (top > 0) ? $urandom_range((top - 1) / SECTORS_PER_BLOCK) : 0;
		if (squeeze)
			hold_req = 1'b1;
		start = n_sent;
		while (n_sent - start < count) begin
			r = $urandom_range(99);
			if (top > 0 && $urandom_range(49) == 0)
				hot_lb = $urandom_range((top - 1) / SECTORS_PER_BLOCK);
			req.write_data = pick_payload();
			if (r < 4 && top > 0) begin
				// Fill a whole block in order, then overwrite one sector of it.
				req.operation = OP_WRITE;
				for (int o = 0; o < SECTORS_PER_BLOCK; o++) begin
					a = hot_lb * SECTORS_PER_BLOCK + o;
					if (a < top) begin
						req.address = ADDR_W'(a);
						req.write_data = pick_payload();
						issue_request(req, 1'b0, '0);
					end
				end
				a = hot_lb * SECTORS_PER_BLOCK + $urandom_range(SECTORS_PER_BLOCK - 1);
				req.address = (a < top) ? ADDR_W'(a) : ADDR_W'($urandom_range(top - 1));
				issue_request(req, 1'b0, '0);
			end else if (r < 60) begin
				req.operation = OP_WRITE;
				req.address = pick_write_addr(top);
				issue_request(req, 1'b0, '0);
			end else if (r < 80 && written_list.size() > 0) begin
				req.operation = OP_READ;
				req.address = ADDR_W'(written_list[$urandom_range(written_list.size() - 1)]);
				issue_request(req, 1'b0, '0);
			end else if (r < 94) begin
				req.operation = OP_MAP;
				req.address = ($urandom_range(3) == 0) ? ADDR_W'($urandom_range(2047))
					: ADDR_W'($urandom_range(NUM_BLOCKS - 1));
				issue_request(req, 1'b0, '0);
			end else if (r < 98) begin
				req.operation = OP_UNKNOWN;
				req.address = ADDR_W'($urandom_range(2047));
				issue_request(req, 1'b0, '0);
			end else begin
				settle_idle();
			end
		end
	endtask

	task automatic flag_result(string what, out_item_t want, out_item_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%s: want st=%0d pb=%0d off=%0d occ=%0d data=%h wr=%0d er=%0d",
				what, want.status, want.physical_block, want.sector_offset, want.occupied,
				want.read_data, want.sector_writes, want.sector_erases,
				"\n    got  st=%0d pb=%0d off=%0d occ=%0d data=%h wr=%0d er=%0d",
				got.status, got.physical_block, got.sector_offset, got.occupied,
				got.read_data, got.sector_writes, got.sector_erases);
	endtask

	// Result side: random stalls, one long hold on request, and the field checks.
	initial begin
		int        stall;
		bit        rx_steady;
		out_item_t got;
		out_item_t want;
		rx_steady = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
				n_holds++;
			end else begin
				if ($urandom_range(19) == 0)
					rx_steady = !rx_steady;
				stall = rx_steady ? 0 : $urandom_range(GAP_MAX);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			got = rsp_ch.data;
			if (pending_results.size() == 0) begin
				flag_result("result with nothing pending", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.physical_block !== want.physical_block
						|| got.sector_offset !== want.sector_offset
						|| got.occupied !== want.occupied || got.read_data !== want.read_data
						|| got.sector_writes !== want.sector_writes
						|| got.sector_erases !== want.sector_erases)
					flag_result("result mismatch", want, got);
			end
		end
	end

	// Request side: reset, directed table, then random phases under several limits.
	initial begin
		int       lims [NUM_PHASES];
		int       counts [NUM_PHASES];
		in_item_t req;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		arst_n <= 1'b0;
		for (int b = 0; b < NUM_BLOCKS; b++)
			map_shadow[b] = BLK_W'(NUM_BLOCKS - 1 - b);
		for (int s = 0; s < TOTAL_SECTORS; s++) begin
			data_shadow[s] = '0;
			used_shadow[s] = 1'b0;
			ever_written[s] = 1'b0;
		end
		limit_shadow = LIMIT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows, checked against typed values where the row gives them.
		for (int i = 0; i < DIR_N; i++) begin
			req.operation = DIR_TAB[i].op;
			req.address = DIR_TAB[i].addr;
			req.write_data = DIR_TAB[i].wdata;
			issue_request(req, DIR_TAB[i].given, DIR_TAB[i].want);
		end

		// Limits go through both extremes, a tight two-block window and random values.
		lims = '{2047, 0, $urandom_range(1983, 1), 33, 1984, $urandom_range(2047)};
		counts = '{350, 60, 330, 260, 350, 300};
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle_idle();
			set_limit(lims[p]);
			run_phase(counts[p], p == 0 || p == 3);
		end
		settle_idle();

		if (pending_results.size() != 0) begin
			$display("%0d expected results never arrived", pending_results.size());
			mismatch_cnt += pending_results.size();
		end
		$display("Covered %0d requests over %0d limit settings: %0d in-place writes,",
			n_sent, n_cfg, n_inplace, " %0d relocations (up to %0d sectors), %0d rejected.",
			n_reloc, max_moved, n_invalid);
		$display("Also %0d sector reads, %0d map reads, %0d long output holds.",
			n_read, n_map, n_holds);
		if (mismatch_cnt == 0)
			$display("block_mapped_flash_translation_tb: done, clean");
		else
			$display("block_mapped_flash_translation_tb: done, errors");
		$finish;
	end

endmodule

// ----- block_mapped_flash_translation.f -----
+incdir+hw/rtl
hw/rtl/bmft_pkg.sv
hw/rtl/bmft_chan_if.sv
hw/rtl/bmft_dpath.sv
hw/rtl/bmft_ctrl.sv
hw/rtl/block_mapped_flash_translation.sv
bench/block_mapped_flash_translation_tb.sv
